/* hdl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared codes, command and status types for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int SIZE_W   = 16;
  localparam int OFF_W    = 10;
  localparam int STAT_W   = 2;
  localparam int MINORD_W = 4;
  localparam int WANT_W   = 5;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd2;

  localparam logic KIND_FREE = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_ERR,
    OP_SCAN,
    OP_POP_RD,
    OP_POP_TAKE,
    OP_PUSH_L,
    OP_PUSH_R,
    OP_OWN_SET,
    OP_FREE_NODE,
    OP_SRCH_START,
    OP_SRCH_RD,
    OP_SRCH_NEXT,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_REMOVE_DONE,
    OP_FPUSH,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic too_large;
    logic ord_over;
    logic ord_empty;
    logic ord_gt_want;
    logic ord_top;
    logic off_oob;
    logic owner_zero;
    logic match;
    logic idx_last;
    logic out_free;
  } stat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_POP,
    S_TAKE,
    S_PUSHL,
    S_PUSHR,
    S_OWN,
    S_FCHK,
    S_SRD,
    S_SCMP,
    S_SHCHK,
    S_SHWR,
    S_FPUSH,
    S_DONE
  } state_t;

endpackage

/* hdl/buddy_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator over a pool of 2^MAX_ORDER bytes with FIFO free lists.
// ----------------------------------------------------------------------------
// Channel     Dir  Signals                       Contents
// s_axis      in   tvalid tready tdata[31:0]     [15:0] request_size, [25:16] free_offset
//                  tuser[0]                      kind (0 allocate, 1 free)
// m_axis      out  tvalid tready tdata[15:0]     [9:0] block_offset, [11:10] status
// min_order   in   min_order_we min_order_wdata  smallest block order
//
// After reset the owner table is cleared one entry at a time; no beat is taken then.
// One request at a time. Allocate: scan up past each empty order, pop the head of the
// first non-empty list, and per split push both halves one order down and pop again;
// then the owner entry is set. Free: search the buddy's list, close its gap and climb
// one order per merge, then push the node. An error goes straight to the result stage.
// A finished result waits in the output register; the next beat is taken meanwhile.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit import bba_pkg::*; #(
  parameter int MAX_ORDER = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                min_order_we,
  input  logic [MINORD_W-1:0] min_order_wdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // request_size, free_offset
  input  logic [0:0]          s_axis_tuser,   // kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata    // block_offset, status
);

  cmd_t                cmd;
  stat_t               stat;
  logic [OFF_W-1:0]    out_off;
  logic [STAT_W-1:0]   out_status;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dpath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .min_order_we    (min_order_we),
    .min_order_wdata (min_order_wdata),
    .in_kind         (s_axis_tuser[0]),
    .in_size         (s_axis_tdata[SIZE_W-1:0]),
    .in_off          (s_axis_tdata[SIZE_W+OFF_W-1:SIZE_W]),
    .out_ready       (m_axis_tready),
    .out_valid       (m_axis_tvalid),
    .out_off         (out_off),
    .out_status      (out_status)
  );

  assign m_axis_tdata = {4'b0, out_status, out_off};

endmodule

/* hdl/bba_ctrl.sv */
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for allocate and free requests; drives datapath commands.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.code   = ST_OK;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.is_free) begin
          if (stat.too_large) begin
            cmd.op     = OP_ERR;
            cmd.code   = ST_NO_SPACE;
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end else if (stat.off_oob || stat.owner_zero) begin
          cmd.op     = OP_ERR;
          cmd.code   = ST_NOT_ALLOC;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_FREE_NODE;
          state_next = S_FCHK;
        end
      end
      S_SCAN: begin
        if (stat.ord_over) begin
          cmd.op     = OP_ERR;
          cmd.code   = ST_NO_SPACE;
          state_next = S_DONE;
        end else if (stat.ord_empty) begin
          cmd.op = OP_SCAN;
        end else begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.op     = OP_POP_RD;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd.op     = OP_POP_TAKE;
        state_next = stat.ord_gt_want ? S_PUSHL : S_OWN;
      end
      S_PUSHL: begin
        cmd.op     = OP_PUSH_L;
        state_next = S_PUSHR;
      end
      S_PUSHR: begin
        cmd.op     = OP_PUSH_R;
        state_next = S_POP;
      end
      S_OWN: begin
        cmd.op     = OP_OWN_SET;
        state_next = S_DONE;
      end
      S_FCHK: begin
        if (stat.ord_top || stat.ord_empty) begin
          state_next = S_FPUSH;
        end else begin
          cmd.op     = OP_SRCH_START;
          state_next = S_SRD;
        end
      end
      S_SRD: begin
        cmd.op     = OP_SRCH_RD;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (stat.match) begin
          state_next = S_SHCHK;
        end else if (stat.idx_last) begin
          state_next = S_FPUSH;
        end else begin
          cmd.op     = OP_SRCH_NEXT;
          state_next = S_SRD;
        end
      end
      S_SHCHK: begin
        // close the gap left by the buddy, then climb one order
        if (stat.idx_last) begin
          cmd.op     = OP_REMOVE_DONE;
          state_next = S_FCHK;
        end else begin
          cmd.op     = OP_SHIFT_RD;
          state_next = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.op     = OP_SHIFT_WR;
        state_next = S_SHCHK;
      end
      S_FPUSH: begin
        cmd.op     = OP_FPUSH;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/bba_dpath.sv */
// ----------------------------------------------------------------------------
// bba_dpath
// Free list store, owner table, per-order list pointers and result register.
// ----------------------------------------------------------------------------
module bba_dpath import bba_pkg::*; #(
  parameter int MAX_ORDER = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                min_order_we,
  input  logic [MINORD_W-1:0] min_order_wdata,
  input  logic                in_kind,
  input  logic [SIZE_W-1:0]   in_size,
  input  logic [OFF_W-1:0]    in_off,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [OFF_W-1:0]    out_off,
  output logic [STAT_W-1:0]   out_status
);

  localparam int AW    = MAX_ORDER + 1;
  localparam int IX_W  = MAX_ORDER;
  localparam int NORD  = MAX_ORDER + 1;
  localparam int OI_W  = $clog2(NORD);
  localparam int ORD_W = $clog2(MAX_ORDER + 2);
  localparam int POOL  = 1 << MAX_ORDER;
  localparam int DEPTH = (1 << AW) - 1;

  logic [AW-1:0] store [DEPTH];
  logic [AW-1:0] owner [POOL];

  logic [AW-1:0]       cnt  [NORD];
  logic [IX_W-1:0]     head [NORD];
  logic [MINORD_W-1:0] min_order;
  logic                kind;
  logic [WANT_W-1:0]   want;
  logic [OFF_W-1:0]    off;
  logic [ORD_W-1:0]    ord;
  logic [AW-1:0]       node;
  logic [IX_W-1:0]     idx;
  logic [OFF_W-1:0]    res_off;
  logic [STAT_W-1:0]   res_status;
  logic [IX_W-1:0]     clr_cnt;
  logic [AW-1:0]       store_rd;
  logic [AW-1:0]       owner_rd;

  logic [OI_W-1:0]      ord_i, om1_i;
  logic [WANT_W-1:0]    want_calc;
  logic [ORD_W-1:0]     ord_of_owner;
  logic [AW-1:0]        blk_ofs;
  logic                 st_we, st_re, own_we, own_re;
  logic [AW-1:0]        st_waddr, st_wdata, st_raddr, own_wdata;
  logic [MAX_ORDER-1:0] own_waddr, own_raddr, off_idx;

  function automatic logic [AW-1:0] lmask(input logic [OI_W-1:0] o);
    return (AW'(1) << (MAX_ORDER - int'(o))) - AW'(1);
  endfunction

  // circular buffer slot k of the list for order o
  function automatic logic [AW-1:0] slot(input logic [OI_W-1:0] o,
                                         input logic [IX_W-1:0] h,
                                         input logic [AW-1:0]   k);
    return lmask(o) + ((AW'(h) + k) & lmask(o));
  endfunction

  assign ord_i = ord[OI_W-1:0];
  assign om1_i = ord_i - OI_W'(1);

  always_comb begin
    logic [SIZE_W-1:0] sm1;
    logic [31:0]       in32;
    logic [31:0]       off32;
    int                dep;
    sm1 = (in_size == '0) ? '0 : in_size - SIZE_W'(1);
    want_calc = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (sm1[i]) want_calc = WANT_W'(i + 1);
    end
    if (want_calc < WANT_W'(min_order)) want_calc = WANT_W'(min_order);
    dep = 0;
    for (int i = 0; i < AW; i++) begin
      if (owner_rd[i]) dep = i;
    end
    ord_of_owner = ORD_W'(MAX_ORDER - dep);
    blk_ofs = (node & lmask(ord_i)) << ord_i;
    in32      = 32'(in_off);
    off32     = 32'(off);
    own_raddr = in32[MAX_ORDER-1:0];
    off_idx   = off32[MAX_ORDER-1:0];
  end

  always_comb begin
    st_we     = 1'b0;
    st_waddr  = '0;
    st_wdata  = '0;
    st_re     = 1'b0;
    st_raddr  = '0;
    own_we    = 1'b0;
    own_waddr = '0;
    own_wdata = '0;
    own_re    = 1'b0;
    case (cmd.op)
      OP_CLEAR: begin
        own_we    = 1'b1;
        own_waddr = clr_cnt;
        // seed the root into the single-entry top-order list
        if (clr_cnt == '0) begin
          st_we    = 1'b1;
          st_waddr = '0;
          st_wdata = AW'(1);
        end
      end
      OP_LOAD: own_re = 1'b1;
      OP_POP_RD: begin
        st_re    = 1'b1;
        st_raddr = slot(ord_i, head[ord_i], '0);
      end
      OP_SRCH_RD: begin
        st_re    = 1'b1;
        st_raddr = slot(ord_i, head[ord_i], AW'(idx));
      end
      OP_SHIFT_RD: begin
        st_re    = 1'b1;
        st_raddr = slot(ord_i, head[ord_i], AW'(idx) + AW'(1));
      end
      OP_SHIFT_WR: begin
        st_we    = 1'b1;
        st_waddr = slot(ord_i, head[ord_i], AW'(idx));
        st_wdata = store_rd;
      end
      OP_PUSH_L: begin
        st_we    = 1'b1;
        st_waddr = slot(om1_i, head[om1_i], cnt[om1_i]);
        st_wdata = {node[AW-2:0], 1'b0};
      end
      OP_PUSH_R: begin
        st_we    = 1'b1;
        st_waddr = slot(om1_i, head[om1_i], cnt[om1_i]);
        st_wdata = {node[AW-2:0], 1'b1};
      end
      OP_OWN_SET: begin
        own_we    = 1'b1;
        own_waddr = blk_ofs[MAX_ORDER-1:0];
        own_wdata = node;
      end
      OP_FPUSH: begin
        own_we    = 1'b1;
        own_waddr = off_idx;
        st_we     = 1'b1;
        st_waddr  = slot(ord_i, head[ord_i], cnt[ord_i]);
        st_wdata  = node;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) store[st_waddr] <= st_wdata;
    if (st_re) store_rd <= store[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (own_we) owner[own_waddr] <= own_wdata;
    if (own_re) owner_rd <= owner[own_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int o = 0; o < NORD; o++) begin
        cnt[o]  <= (o == MAX_ORDER) ? AW'(1) : '0;
        head[o] <= '0;
      end
      min_order <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (min_order_we) min_order <= min_order_wdata;
      if (cmd.op == OP_RESULT) begin
        out_valid  <= 1'b1;
        out_off    <= res_off;
        out_status <= res_status;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: clr_cnt <= clr_cnt + IX_W'(1);
        OP_LOAD: begin
          kind       <= in_kind;
          off        <= in_off;
          want       <= want_calc;
          ord        <= ORD_W'(want_calc);
          res_off    <= '0;
          res_status <= ST_OK;
        end
        OP_ERR:  res_status <= cmd.code;
        OP_SCAN: ord <= ord + ORD_W'(1);
        OP_POP_TAKE: begin
          node        <= store_rd;
          head[ord_i] <= IX_W'((AW'(head[ord_i]) + AW'(1)) & lmask(ord_i));
          cnt[ord_i]  <= cnt[ord_i] - AW'(1);
        end
        OP_PUSH_L: cnt[om1_i] <= cnt[om1_i] + AW'(1);
        OP_PUSH_R: begin
          cnt[om1_i] <= cnt[om1_i] + AW'(1);
          ord        <= ord - ORD_W'(1);
        end
        OP_OWN_SET: res_off <= OFF_W'(32'(blk_ofs));
        OP_FREE_NODE: begin
          node <= owner_rd;
          ord  <= ord_of_owner;
        end
        OP_SRCH_START: idx <= '0;
        OP_SRCH_NEXT:  idx <= idx + IX_W'(1);
        OP_SHIFT_WR:   idx <= idx + IX_W'(1);
        OP_REMOVE_DONE: begin
          cnt[ord_i] <= cnt[ord_i] - AW'(1);
          ord        <= ord + ORD_W'(1);
          node       <= node >> 1;
        end
        OP_FPUSH: cnt[ord_i] <= cnt[ord_i] + AW'(1);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat.clr_last    = &clr_cnt;
    stat.is_free     = (kind == KIND_FREE);
    stat.too_large   = 8'(want) > 8'(MAX_ORDER);
    stat.ord_over    = 8'(ord) > 8'(MAX_ORDER);
    stat.ord_empty   = (cnt[ord_i] == '0);
    stat.ord_gt_want = 8'(ord) > 8'(want);
    stat.ord_top     = 8'(ord) >= 8'(MAX_ORDER);
    stat.off_oob     = 32'(off) >= POOL;
    stat.owner_zero  = (owner_rd == '0);
    stat.match       = (store_rd == (node ^ AW'(1)));
    stat.idx_last    = (AW'(idx) + AW'(1)) == cnt[ord_i];
    stat.out_free    = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_POP_RD) |-> (cnt[ord_i] != '0))
    else $error("pop from an empty free list");
  a_pop_node: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_POP_TAKE) |-> (store_rd != '0))
    else $error("popped node is zero");
  a_split_order: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PUSH_L) |-> (ord_i != '0))
    else $error("split below order zero");
  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_RESULT) |-> stat.out_free)
    else $error("result overwrites a pending beat");
`endif

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buddy block allocator. Allocate and free
// requests go in through a queue-fed driver; a monitor compares each result
// beat against an in-bench buddy allocator, under several min_order settings
// and several idling phases on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXO = 10;
  localparam int POOL = 1 << MAXO;
  localparam logic KIND_ALLOC = 1'b0;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic        kind;
    logic [15:0] req_size;
    logic [9:0]  free_off;
  } request_t;

  typedef struct packed {
    logic [9:0]        blk_off;
    logic [STAT_W-1:0] status;
  } grant_t;

  logic clk = 0;
  logic rst = 1;
  logic min_order_we = 0;
  logic [MINORD_W-1:0] min_order_wdata = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [15:0] m_axis_tdata;

  buddy_block_allocator_unit #(.MAX_ORDER(MAXO)) DUT (.*);

  // allocator state mirror
  int free_lists[MAXO+1][$];
  int owner_node[POOL];
  int min_ord;

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  int send_idle_pct, recv_stall_pct;
  int errors, cycles;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int node_depth(int node);
    int d;
    d = 0;
    while ((node >> (d + 1)) != 0) d++;
    return d;
  endfunction

  function automatic int list_take(int ord);
    int node;
    node = free_lists[ord][0];
    free_lists[ord].delete(0);
    return node;
  endfunction

  function automatic void list_append(int ord, int node);
    free_lists[ord].insert(free_lists[ord].size(), node);
  endfunction

  function automatic bit drop_free(int ord, int node);
    foreach (free_lists[ord][i]) begin
      if (free_lists[ord][i] == node) begin
        free_lists[ord].delete(i);
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic grant_t predict_grant(request_t r);
    grant_t g;
    int want, ord, node, sz, off;
    g = '0;
    if (r.kind == KIND_ALLOC) begin
      sz = (r.req_size == 0) ? 1 : int'(r.req_size);
      want = 0;
      while ((1 << want) < sz) want++;
      if (want < min_ord) want = min_ord;
      if (want > MAXO) g.status = ST_NO_SPACE;
      else begin
        ord = want;
        while (ord <= MAXO && free_lists[ord].size() == 0) ord++;
        if (ord > MAXO) g.status = ST_NO_SPACE;
        else begin
          while (ord > want) begin
            node = list_take(ord);
            list_append(ord - 1, node * 2);
            list_append(ord - 1, node * 2 + 1);
            ord--;
          end
          node = list_take(want);
          off = (node - (1 << node_depth(node))) << want;
          owner_node[off] = node;
          g.blk_off = 10'(off);
          g.status = ST_OK;
        end
      end
    end else begin
      off = int'(r.free_off);
      if (owner_node[off] == 0) g.status = ST_NOT_ALLOC;
      else begin
        node = owner_node[off];
        ord = MAXO - node_depth(node);
        while (ord < MAXO && drop_free(ord, node ^ 1)) begin
          ord++;
          node >>= 1;
        end
        owner_node[off] = 0;
        list_append(ord, node);
      end
    end
    return g;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) s_axis_tvalid <= 0;
    else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t r;
        r = pending_reqs[0];
        pending_reqs.delete(0);
        expected_grants.insert(expected_grants.size(), predict_grant(r));
        s_axis_tvalid <= 1;
        s_axis_tdata <= {6'd0, r.free_off, r.req_size};
        s_axis_tuser <= r.kind;
      end else s_axis_tvalid <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, m_axis_tdata);
        errors++;
      end else begin
        grant_t e;
        e = expected_grants[0];
        expected_grants.delete(0);
        if (m_axis_tdata[9:0] !== e.blk_off) begin
          $display("%0t: block_offset expected %0d actual %0d", $time, e.blk_off,
                   m_axis_tdata[9:0]);
          errors++;
        end
        if (m_axis_tdata[11:10] !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status,
                   m_axis_tdata[11:10]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("buddy_block_allocator_unit test failed");
      $finish;
    end
  end

  // offsets that currently hold a block, as seen by the stimulus generator
  int live_offs[$];

  task automatic queue_req(bit kind, int sz, int off);
    request_t r;
    r.kind = kind;
    r.req_size = 16'(sz);
    r.free_off = 10'(off);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_min_order(int v);
    @(posedge clk);
    min_order_we <= 1;
    min_order_wdata <= MINORD_W'(v);
    min_ord = v;
    @(posedge clk);
    min_order_we <= 0;
  endtask

  // mostly alloc/free of live blocks, with some noise offsets
  task automatic random_phase(int n, int idle_s, int stall_r);
    int k, off;
    send_idle_pct = idle_s;
    recv_stall_pct = stall_r;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 50) begin
        case ($urandom_range(3))
          0: queue_req(KIND_ALLOC, $urandom_range(65535), $urandom_range(1023));
          1: queue_req(KIND_ALLOC, $urandom_range(1024), $urandom_range(1023));
          default: queue_req(KIND_ALLOC, $urandom_range(64), $urandom_range(1023));
        endcase
      end else if (k < 90 && live_offs.size() > 0) begin
        int j;
        j = $urandom_range(live_offs.size() - 1);
        queue_req(KIND_FREE, $urandom_range(65535), live_offs[j]);
        live_offs.delete(j);
      end else queue_req(KIND_FREE, $urandom_range(65535), $urandom_range(1023));
      // track offsets from the predictor once this item is predicted
      while (pending_reqs.size() > 0) @(posedge clk);
      live_offs.delete();
      foreach (owner_node[o]) if (owner_node[o] != 0) live_offs.insert(live_offs.size(), o);
    end
    drain();
  endtask

  initial begin
    for (int o = 0; o < MAXO + 1; o++) free_lists[o].delete();
    foreach (owner_node[o]) owner_node[o] = 0;
    list_append(MAXO, 1);
    min_ord = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    repeat (POOL + 20) @(posedge clk);
    // directed: extremes, splits, merges, errors
    queue_req(KIND_ALLOC, 0, 0);
    queue_req(KIND_ALLOC, 1, 1023);
    queue_req(KIND_ALLOC, 65535, 0);
    queue_req(KIND_ALLOC, 1025, 0);
    queue_req(KIND_ALLOC, 3, 0);
    queue_req(KIND_FREE, 0, 1);
    queue_req(KIND_FREE, 0, 1);
    queue_req(KIND_FREE, 0, 5);
    queue_req(KIND_FREE, 65535, 1023);
    queue_req(KIND_FREE, 0, 0);
    queue_req(KIND_FREE, 0, 4);
    queue_req(KIND_ALLOC, 1024, 0);
    queue_req(KIND_ALLOC, 1, 0);
    queue_req(KIND_FREE, 0, 0);
    queue_req(KIND_ALLOC, 512, 0);
    queue_req(KIND_ALLOC, 512, 0);
    queue_req(KIND_ALLOC, 1, 0);
    queue_req(KIND_FREE, 0, 512);
    queue_req(KIND_FREE, 0, 0);
    queue_req(KIND_FREE, 0, 1023);
    drain();
    set_min_order(15);
    queue_req(KIND_ALLOC, 1, 0);
    queue_req(KIND_FREE, 0, 0);
    drain();
    set_min_order(10);
    queue_req(KIND_ALLOC, 1, 0);
    queue_req(KIND_FREE, 0, 0);
    drain();
    set_min_order(0);
    random_phase(100, 0, 0);
    set_min_order(4);
    random_phase(100, 67, 0);
    set_min_order(0);
    random_phase(100, 0, 67);
    set_min_order(2);
    random_phase(100, 14, 14);
    if (errors == 0) $display("buddy_block_allocator_unit test passed");
    else $display("buddy_block_allocator_unit test failed");
    $finish;
  end
endmodule

/* files.f */
hdl/bba_pkg.sv
hdl/bba_ctrl.sv
hdl/bba_dpath.sv
hdl/buddy_block_allocator_unit.sv
sim/tb_top.sv
